[rtl/vdk4_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vdk4_pkg
// Shared types, constants and helpers of the K=4 rate 1/2 Viterbi decoder.
// ---------------------------------------------------------------------------
package vdk4_pkg;

	localparam int NUM_ROWS         = 32;
	localparam int NUM_STATES       = NUM_ROWS / 2;
	localparam int SW               = $clog2(NUM_STATES);
	localparam int HIGH_BIT         = NUM_STATES / 2;
	localparam int MW               = 16;
	localparam int SYM_W            = 2;
	localparam int SYMS_PER_BYTE    = 4;
	localparam int KW               = $clog2(SYMS_PER_BYTE);
	localparam int BYTE_W           = 8;
	localparam int DEF_MAX_IN_BYTES = 64;

	typedef logic [SW-1:0]         state_t;
	typedef logic [MW-1:0]         metric_t;
	typedef logic [NUM_STATES-1:0] dec_t;

	localparam dec_t REACH_INIT = dec_t'((1 << 0) | (1 << HIGH_BIT));

	typedef struct packed {
		logic step_en;
		logic min_start;
		logic clear;
	} pm_ctl_t;

	typedef struct packed {
		logic    min_done;
		state_t  best_state;
		metric_t best_metric;
	} pm_res_t;

	// code symbol of a state: bit0 = s0^s1^s2^s3, bit1 = s0^s2^s3
	function automatic logic [SYM_W-1:0] exp_sym(input state_t s);
		return {s[0] ^ s[2] ^ s[3], ^s};
	endfunction

endpackage

[rtl/vdk4_pm.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vdk4_pm
// Path metric unit: 16 add-compare-select cells in one step, and a scan
// over the states for the lowest reachable metric.
// ---------------------------------------------------------------------------
module vdk4_pm (
	input  logic                               clk,
	input  logic                               arst_n,
	input  vdk4_pkg::pm_ctl_t                  ctl,
	input  logic [vdk4_pkg::SYM_W-1:0]         sym,
	output vdk4_pkg::dec_t                     dec,
	output vdk4_pkg::pm_res_t                  res
);
	import vdk4_pkg::*;

	metric_t metric_q [NUM_STATES];
	dec_t    reach_q;
	metric_t nm [NUM_STATES];
	dec_t    nr;
	dec_t    dec_c;

	logic    scan_act_q;
	state_t  scan_q;
	logic    found_q;
	state_t  best_state_q;
	metric_t best_metric_q;
	logic    done_q;

	always_comb begin
		state_t           p0;
		state_t           p1;
		logic [SYM_W-1:0] diff;
		logic [1:0]       bm;
		logic             hi;
		metric_t          base;
		logic [MW:0]      sum;
		p0    = '0;
		p1    = '0;
		diff  = '0;
		bm    = '0;
		hi    = 1'b0;
		base  = '0;
		sum   = '0;
		dec_c = '0;
		nr    = '0;
		for (int s = 0; s < NUM_STATES; s++) begin
			p0   = state_t'(s) >> 1;
			p1   = p0 | state_t'(HIGH_BIT);
			diff = sym ^ exp_sym(state_t'(s));
			bm   = {1'b0, diff[1]} + {1'b0, diff[0]};
			if (!reach_q[p0] && !reach_q[p1]) begin
				nm[s] = '0;
			end else begin
				if (!reach_q[p0])
					hi = 1'b1;
				else if (!reach_q[p1])
					hi = 1'b0;
				else
					hi = metric_q[p1] < metric_q[p0];
				base     = hi ? metric_q[p1] : metric_q[p0];
				sum      = {1'b0, base} + (MW+1)'(bm);
				nm[s]    = sum[MW] ? '1 : sum[MW-1:0];
				nr[s]    = 1'b1;
				dec_c[s] = hi;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_STATES; s++)
				metric_q[s] <= '0;
			reach_q       <= REACH_INIT;
			scan_act_q    <= 1'b0;
			scan_q        <= '0;
			found_q       <= 1'b0;
			best_state_q  <= '0;
			best_metric_q <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= scan_act_q && !ctl.min_start
				&& (scan_q == state_t'(NUM_STATES - 1));
			if (ctl.clear) begin
				for (int s = 0; s < NUM_STATES; s++)
					metric_q[s] <= '0;
				reach_q <= REACH_INIT;
			end else if (ctl.step_en) begin
				for (int s = 0; s < NUM_STATES; s++)
					metric_q[s] <= nm[s];
				reach_q <= nr;
			end
			if (ctl.min_start) begin
				scan_act_q <= 1'b1;
				scan_q     <= '0;
				found_q    <= 1'b0;
			end else if (scan_act_q) begin
				if (reach_q[scan_q] && (!found_q || metric_q[scan_q] < best_metric_q)) begin
					found_q       <= 1'b1;
					best_state_q  <= scan_q;
					best_metric_q <= metric_q[scan_q];
				end
				if (scan_q == state_t'(NUM_STATES - 1)) begin
					scan_act_q <= 1'b0;
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end
		end
	end

	assign dec             = dec_c;
	assign res.min_done    = done_q;
	assign res.best_state  = best_state_q;
	assign res.best_metric = best_metric_q;

endmodule

[rtl/vdk4_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vdk4_tb
// Survivor memory and traceback: one decision word stored per cycle while sv_we is high,
// decoded bits packed into bytes and written to the output buffer.
// ---------------------------------------------------------------------------
module vdk4_tb #(
	parameter int MAX_IN_BYTES = vdk4_pkg::DEF_MAX_IN_BYTES
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                sv_we,
	input  logic [$clog2(vdk4_pkg::SYMS_PER_BYTE*MAX_IN_BYTES)-1:0] sv_addr,
	input  vdk4_pkg::dec_t                                      sv_data,
	input  logic                                                start,
	input  logic [$clog2(vdk4_pkg::SYMS_PER_BYTE*MAX_IN_BYTES)-1:0] t_first,
	input  vdk4_pkg::state_t                                    start_state,
	output logic                                                ob_we,
	output logic [((MAX_IN_BYTES+1)/2 > 1 ? $clog2((MAX_IN_BYTES+1)/2) : 1)-1:0] ob_addr,
	output logic [vdk4_pkg::BYTE_W-1:0]                         ob_data,
	output logic                                                done
);
	import vdk4_pkg::*;

	localparam int MAX_SYMBOLS = SYMS_PER_BYTE * MAX_IN_BYTES;
	localparam int AW          = $clog2(MAX_SYMBOLS);
	localparam int NBYTE_MAX   = (MAX_IN_BYTES + 1) / 2;
	localparam int OBW         = NBYTE_MAX > 1 ? $clog2(NBYTE_MAX) : 1;

	dec_t              mem [MAX_SYMBOLS];
	dec_t              rdata_s1;
	logic              run_q;
	logic [AW-1:0]     t_q;
	logic [AW-1:0]     t_s1;
	logic              rv_s1;
	state_t            st_q;
	logic [BYTE_W-1:0] byte_q;
	logic              done_q;
	logic [2:0]        pos;
	logic [BYTE_W-1:0] byte_c;

	assign pos     = t_s1[2:0];
	assign byte_c  = byte_q | (BYTE_W'(st_q[0]) << pos);
	assign ob_we   = rv_s1 && (pos == 3'd0);
	assign ob_addr = OBW'(t_s1 >> 3);
	assign ob_data = byte_c;
	assign done    = done_q;

	always_ff @(posedge clk) begin
		if (sv_we)
			mem[sv_addr] <= sv_data;
		if (run_q)
			rdata_s1 <= mem[t_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			t_q    <= '0;
			t_s1   <= '0;
			rv_s1  <= 1'b0;
			st_q   <= '0;
			byte_q <= '0;
			done_q <= 1'b0;
		end else begin
			rv_s1  <= run_q;
			t_s1   <= t_q;
			done_q <= rv_s1 && (t_s1 == '0);
			if (start) begin
				run_q  <= 1'b1;
				t_q    <= t_first;
				st_q   <= start_state;
				byte_q <= '0;
			end else begin
				if (run_q) begin
					if (t_q == '0)
						run_q <= 1'b0;
					else
						t_q <= t_q - 1'b1;
				end
				if (rv_s1) begin
					st_q   <= {rdata_s1[st_q], st_q[SW-1:1]};
					byte_q <= (pos == 3'd0) ? '0 : byte_c;
				end
			end
		end
	end

endmodule

[rtl/vdk4_emit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vdk4_emit
// Decoded byte buffer and output stage: plays the block out in order,
// the final metric and last flag on the final item.
// ---------------------------------------------------------------------------
module vdk4_emit #(
	parameter int MAX_IN_BYTES = vdk4_pkg::DEF_MAX_IN_BYTES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                ob_we,
	input  logic [((MAX_IN_BYTES+1)/2 > 1 ? $clog2((MAX_IN_BYTES+1)/2) : 1)-1:0] ob_addr,
	input  logic [vdk4_pkg::BYTE_W-1:0]         ob_data,
	input  logic                                start,
	input  logic [((MAX_IN_BYTES+1)/2 > 1 ? $clog2((MAX_IN_BYTES+1)/2) : 1)-1:0] last_idx,
	input  vdk4_pkg::metric_t                   metric,
	output logic                                busy,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [vdk4_pkg::BYTE_W-1:0]         decoded_byte,
	output vdk4_pkg::metric_t                   final_metric,
	output logic                                last_out
);
	import vdk4_pkg::*;

	localparam int NBYTE_MAX = (MAX_IN_BYTES + 1) / 2;
	localparam int OBW       = NBYTE_MAX > 1 ? $clog2(NBYTE_MAX) : 1;

	typedef enum logic [1:0] {E_IDLE, E_LD, E_WAIT} est_t;

	est_t              state_q;
	logic [BYTE_W-1:0] mem [NBYTE_MAX];
	logic [BYTE_W-1:0] rdata_q;
	logic [OBW-1:0]    addr_q;
	logic [OBW-1:0]    last_q;
	metric_t           metric_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] dbyte_q;
	metric_t           fmetric_q;
	logic              last_out_q;
	logic              is_last;
	logic              rd_en;
	logic [OBW-1:0]    rd_addr;

	assign is_last = addr_q == last_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_q + 1'b1;
		unique case (state_q)
			E_IDLE: begin
				rd_en   = start;
				rd_addr = '0;
			end
			E_WAIT: rd_en = out_ready && !is_last;
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ob_we)
			mem[ob_addr] <= ob_data;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= E_IDLE;
			addr_q      <= '0;
			last_q      <= '0;
			metric_q    <= '0;
			out_valid_q <= 1'b0;
			dbyte_q     <= '0;
			fmetric_q   <= '0;
			last_out_q  <= 1'b0;
		end else begin
			unique case (state_q)
				E_IDLE: begin
					if (start) begin
						addr_q   <= '0;
						last_q   <= last_idx;
						metric_q <= metric;
						state_q  <= E_LD;
					end
				end
				E_LD: begin
					dbyte_q     <= rdata_q;
					last_out_q  <= is_last;
					fmetric_q   <= is_last ? metric_q : '0;
					out_valid_q <= 1'b1;
					state_q     <= E_WAIT;
				end
				E_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (is_last) begin
							state_q <= E_IDLE;
						end else begin
							addr_q  <= addr_q + 1'b1;
							state_q <= E_LD;
						end
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	assign busy         = state_q != E_IDLE;
	assign out_valid    = out_valid_q;
	assign decoded_byte = dbyte_q;
	assign final_metric = fmetric_q;
	assign last_out     = last_out_q;

`ifndef NO_ASSERTIONS
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ob_we |-> state_q == E_IDLE)
		else $error("byte buffer written while playing out");
	a_valid_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == E_WAIT)
		else $error("output item shown outside wait state");
`endif

endmodule

[rtl/viterbi_decoder_k4_rate_half.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// viterbi_decoder_k4_rate_half
// Hard-decision Viterbi decoder, rate 1/2, 16 states: per-byte ACS over
// four symbols, survivor memory, traceback and in-order byte output.
// ---------------------------------------------------------------------------
// input: one ACS step per symbol, four per received byte; the next byte can be
//   taken in the last ACS step of the one before unless that one was the last
// block end: ACS over the last byte, min scan over the states, traceback over
//   the n stored symbols, then the decoded items played out in order
// a new block may be fed while the previous one is still being played out
// reset: metrics cleared, states 0 and 8 reachable, symbol count zero
module viterbi_decoder_k4_rate_half #(
	parameter int MAX_IN_BYTES = vdk4_pkg::DEF_MAX_IN_BYTES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [vdk4_pkg::BYTE_W-1:0] code_byte,
	input  logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [vdk4_pkg::BYTE_W-1:0] decoded_byte,
	output vdk4_pkg::metric_t           final_metric,
	output logic                        last_out
);
	import vdk4_pkg::*;

	localparam int MAX_SYMBOLS = SYMS_PER_BYTE * MAX_IN_BYTES;
	localparam int AW          = $clog2(MAX_SYMBOLS);
	localparam int CW          = $clog2(MAX_SYMBOLS + 1);
	localparam int NBYTE_MAX   = (MAX_IN_BYTES + 1) / 2;
	localparam int OBW         = NBYTE_MAX > 1 ? $clog2(NBYTE_MAX) : 1;

	typedef enum logic [2:0] {S_IDLE, S_ACS, S_MIN, S_HOLD, S_TB} st_t;

	st_t               state_q;
	logic [BYTE_W-1:0] code_q;
	logic              last_q;
	logic [KW-1:0]     k_q;
	logic [CW-1:0]     count_q;

	logic              step;
	logic              acs_end;
	logic [CW-1:0]     cnt_next;
	logic [CW-1:0]     cnt_m1;
	logic              accept;
	logic              room;
	st_t               acc_next;
	logic              tb_start;
	logic              tb_done;
	logic              emit_busy;
	logic [SYM_W-1:0]  sym;
	pm_ctl_t           pm_ctl;
	pm_res_t           pm_res;
	dec_t              dec;
	logic              ob_we;
	logic [OBW-1:0]    ob_addr;
	logic [BYTE_W-1:0] ob_data;

	assign step     = state_q == S_ACS;
	assign acs_end  = step && (k_q == KW'(SYMS_PER_BYTE - 1));
	assign cnt_next = step ? count_q + 1'b1 : count_q;
	assign cnt_m1   = count_q - 1'b1;
	assign in_ready = (state_q == S_IDLE) || (acs_end && !last_q);
	assign accept   = in_valid && in_ready;
	assign room     = cnt_next != CW'(MAX_SYMBOLS);
	assign acc_next = room ? S_ACS : (last_byte ? S_MIN : S_IDLE);
	assign tb_start = (state_q == S_HOLD) && !emit_busy;
	assign sym      = code_q[{k_q, 1'b0} +: SYM_W];

	assign pm_ctl.step_en   = step;
	assign pm_ctl.min_start = (accept && !room && last_byte) || (acs_end && last_q);
	assign pm_ctl.clear     = (state_q == S_TB) && tb_done;

	vdk4_pm u_pm (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pm_ctl),
		.sym    (sym),
		.dec    (dec),
		.res    (pm_res)
	);

	vdk4_tb #(
		.MAX_IN_BYTES (MAX_IN_BYTES)
	) u_tb (
		.clk         (clk),
		.arst_n      (arst_n),
		.sv_we       (step),
		.sv_addr     (count_q[AW-1:0]),
		.sv_data     (dec),
		.start       (tb_start),
		.t_first     (cnt_m1[AW-1:0]),
		.start_state (pm_res.best_state),
		.ob_we       (ob_we),
		.ob_addr     (ob_addr),
		.ob_data     (ob_data),
		.done        (tb_done)
	);

	vdk4_emit #(
		.MAX_IN_BYTES (MAX_IN_BYTES)
	) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.ob_we        (ob_we),
		.ob_addr      (ob_addr),
		.ob_data      (ob_data),
		.start        (pm_ctl.clear),
		.last_idx     (OBW'(cnt_m1 >> 3)),
		.metric       (pm_res.best_metric),
		.busy         (emit_busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.decoded_byte (decoded_byte),
		.final_metric (final_metric),
		.last_out     (last_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= '0;
			last_q  <= 1'b0;
			k_q     <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						code_q  <= code_byte;
						last_q  <= last_byte;
						k_q     <= '0;
						state_q <= acc_next;
					end
				end
				S_ACS: begin
					// symbol index wraps to zero after the fourth step
					count_q <= cnt_next;
					k_q     <= k_q + 1'b1;
					if (acs_end) begin
						if (last_q) begin
							state_q <= S_MIN;
						end else if (accept) begin
							code_q  <= code_byte;
							last_q  <= last_byte;
							state_q <= acc_next;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_MIN: begin
					if (pm_res.min_done)
						state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (!emit_busy)
						state_q <= S_TB;
				end
				S_TB: begin
					if (tb_done) begin
						count_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SYMBOLS))
		else $error("symbol count beyond survivor memory");
	a_tb_free: assert property (@(posedge clk) disable iff (!arst_n)
		tb_start |-> !emit_busy)
		else $error("traceback started while byte buffer in use");
	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		accept && room |=> state_q == S_ACS && k_q == '0)
		else $error("accepted item with room did not start acs");
`endif

endmodule
